FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the SHA-1 digest back end (sha1_back).
// Relies on the including module having signals named clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SHA1_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SHA1_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define SHA1_ASSERT(lbl, prop, msg)
`define SHA1_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: hw/rtl/sha1_pkg.sv
`timescale 1ns / 1ps
// Package for the SHA-1 digest unit: request type, queue sizing and algorithm constants.
// Used by sha1_front, sha1_back and the top level; depends on nothing.
package sha1_pkg;

  localparam int QDepth = 4;
  localparam int QAw = $clog2(QDepth);

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LastPos = 6'd63;
  localparam logic [6:0] LastRound = 7'd79;
  localparam logic [2:0] LastWord = 3'd4;

  localparam logic [31:0] InitChain [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] RoundK0 = 32'h5A827999;
  localparam logic [31:0] RoundK1 = 32'h6ED9EBA1;
  localparam logic [31:0] RoundK2 = 32'h8F1BBCDC;
  localparam logic [31:0] RoundK3 = 32'hCA62C1D6;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       end_of_message;
  } cmd_t;

endpackage

FILE: hw/rtl/sha1_message_digest_unit.sv
`timescale 1ns / 1ps
// Top level of the SHA-1 digest unit: joins the request queue front end to the compression back end.
// Depends on sha1_pkg, sha1_front and sha1_back.
//
// The input stream carries one message byte per request in s_axis_tdata, with
// s_axis_tuser high when the byte belongs to the message and s_axis_tlast high on the
// request that ends the message. A request with tuser and tlast both low is dropped.
// For each message the output stream gives five digest words, most significant first,
// with the word index in m_axis_tuser and m_axis_tlast on the fifth word.
// The back end takes request bytes only in its absorb state. Every full 64-byte block
// is compressed by 80 rounds of the single round unit and then folded into the chain
// value. A four-entry request queue keeps taking input while a block is compressed or
// the digest waits.
// After the ending request, the padding bytes fill the rest of the block one per
// cycle and compression follows. When the last block held 56 or more message bytes,
// a second block of padding and another compression come next. Then the five words
// appear one per cycle while the receiver is ready.
// If the receiver stalls, the current word holds and the back end waits; the queue
// fills and then deasserts s_axis_tready. Reset empties the queue, loads the initial
// chain value and clears the byte and bit counts.
module sha1_message_digest_unit
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // msg_byte
  input  logic        s_axis_tuser,  // has_byte
  input  logic        s_axis_tlast,  // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // digest_word
  output logic [2:0]  m_axis_tuser,  // word_index
  output logic        m_axis_tlast   // last_word
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  sha1_front u_front (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd)
  );

  sha1_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

FILE: hw/rtl/sha1_front.sv
`timescale 1ns / 1ps
// Front end of the SHA-1 digest unit: accepts input requests, drops idle ones, queues the rest.
// Depends on sha1_pkg.
module sha1_front
  import sha1_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // msg_byte
  input  logic       s_axis_tuser,  // has_byte
  input  logic       s_axis_tlast,  // end_of_message
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output cmd_t       cmd
);

  cmd_t           q [QDepth];
  logic [QAw-1:0] wr_ptr;
  logic [QAw-1:0] rd_ptr;
  logic [QAw:0]   count;
  logic           keep;
  logic           push;
  logic           pop;

  assign keep = s_axis_tuser | s_axis_tlast;
  assign s_axis_tready = (count != (QAw+1)'(QDepth));
  assign push = s_axis_tvalid && s_axis_tready && keep;
  assign cmd_valid = (count != '0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{msg_byte: s_axis_tdata, has_byte: s_axis_tuser,
                     end_of_message: s_axis_tlast};
    end
  end

endmodule

FILE: hw/rtl/sha1_back.sv
`timescale 1ns / 1ps
// Back end of the SHA-1 digest unit: block shift line, padding, 80-round compression, output.
// Depends on sha1_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sha1_back
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // digest_word
  output logic [2:0]  m_axis_tuser,  // word_index
  output logic        m_axis_tlast   // last_word
);

  typedef enum logic [4:0] {
    ST_ABSORB = 5'b00001,
    ST_PAD    = 5'b00010,
    ST_ROUND  = 5'b00100,
    ST_FOLD   = 5'b01000,
    ST_OUT    = 5'b10000
  } state_t;

  state_t       state;
  logic [511:0] line;
  logic [5:0]   pos;
  logic [63:0]  bit_count;
  logic [31:0]  chain [5];
  logic [31:0]  wa, wb, wc, wd, we;
  logic [6:0]   rnd;
  logic         pad_first;
  logic         tail_ok;
  logic         ending;
  logic         final_blk;
  logic [2:0]   out_idx;

  logic [63:0]  len_shift;
  logic [7:0]   pad_byte;
  logic [31:0]  sched_x;
  logic [31:0]  w_new;
  logic [31:0]  f;
  logic [31:0]  k;
  logic [31:0]  t;

  assign cmd_ready = (state == ST_ABSORB);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata = chain[out_idx];
  assign m_axis_tuser = out_idx;
  assign m_axis_tlast = (out_idx == LastWord);

  // The length goes out most significant byte first in the last eight positions.
  assign len_shift = bit_count >> {~pos[2:0], 3'b000};

  always_comb begin
    if (pad_first) begin
      pad_byte = PadByte;
    end else if (tail_ok && (pos[5:3] == 3'b111)) begin
      pad_byte = len_shift[7:0];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign sched_x = line[95:64] ^ line[255:224] ^ line[447:416] ^ line[511:480];
  assign w_new = {sched_x[30:0], sched_x[31]};

  always_comb begin
    if (rnd < 7'd20) begin
      f = (wb & wc) | (~wb & wd);
      k = RoundK0;
    end else if (rnd < 7'd40) begin
      f = wb ^ wc ^ wd;
      k = RoundK1;
    end else if (rnd < 7'd60) begin
      f = (wb & wc) | (wb & wd) | (wc & wd);
      k = RoundK2;
    end else begin
      f = wb ^ wc ^ wd;
      k = RoundK3;
    end
  end

  assign t = {wa[26:0], wa[31:27]} + f + we + line[511:480] + k;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ABSORB;
      pos <= '0;
      bit_count <= '0;
      rnd <= '0;
      pad_first <= 1'b0;
      tail_ok <= 1'b0;
      ending <= 1'b0;
      final_blk <= 1'b0;
      out_idx <= '0;
      for (int i = 0; i < 5; i++) begin
        chain[i] <= InitChain[i];
      end
    end else begin
      unique case (state)
        ST_ABSORB: begin
          if (cmd_valid) begin
            if (cmd.has_byte) begin
              line <= {line[503:0], cmd.msg_byte};
              pos <= pos + 6'd1;
              bit_count <= bit_count + 64'd8;
              if (pos == LastPos) begin
                state <= ST_ROUND;
                rnd <= '0;
                pad_first <= cmd.end_of_message;
                ending <= cmd.end_of_message;
                final_blk <= 1'b0;
                wa <= chain[0];
                wb <= chain[1];
                wc <= chain[2];
                wd <= chain[3];
                we <= chain[4];
              end else if (cmd.end_of_message) begin
                state <= ST_PAD;
                pad_first <= 1'b1;
                ending <= 1'b1;
              end
            end else begin
              state <= ST_PAD;
              pad_first <= 1'b1;
              ending <= 1'b1;
            end
          end
        end
        ST_PAD: begin
          line <= {line[503:0], pad_byte};
          pos <= pos + 6'd1;
          if (pad_first) begin
            pad_first <= 1'b0;
          end
          if (pos == LastPos) begin
            state <= ST_ROUND;
            rnd <= '0;
            final_blk <= !pad_first && tail_ok;
            tail_ok <= 1'b1;
            wa <= chain[0];
            wb <= chain[1];
            wc <= chain[2];
            wd <= chain[3];
            we <= chain[4];
          end else if (pad_first) begin
            tail_ok <= (pos[5:3] != 3'b111);
          end
        end
        ST_ROUND: begin
          wa <= t;
          wb <= wa;
          wc <= {wb[1:0], wb[31:2]};
          wd <= wc;
          we <= wd;
          line <= {line[479:0], w_new};
          if (rnd == LastRound) begin
            state <= ST_FOLD;
            rnd <= '0;
          end else begin
            rnd <= rnd + 7'd1;
          end
        end
        ST_FOLD: begin
          chain[0] <= chain[0] + wa;
          chain[1] <= chain[1] + wb;
          chain[2] <= chain[2] + wc;
          chain[3] <= chain[3] + wd;
          chain[4] <= chain[4] + we;
          if (final_blk) begin
            state <= ST_OUT;
            out_idx <= '0;
          end else if (ending) begin
            state <= ST_PAD;
          end else begin
            state <= ST_ABSORB;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            if (out_idx == LastWord) begin
              state <= ST_ABSORB;
              out_idx <= '0;
              bit_count <= '0;
              pos <= '0;
              tail_ok <= 1'b0;
              ending <= 1'b0;
              final_blk <= 1'b0;
              for (int i = 0; i < 5; i++) begin
                chain[i] <= InitChain[i];
              end
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: begin
          state <= ST_ABSORB;
        end
      endcase
    end
  end

  `SHA1_ASSERT_NEXT(a_pad_len_stable, state == ST_PAD, $stable(bit_count), "bit count moved while padding")
  `SHA1_ASSERT(a_round_aligned, (state == ST_ROUND || state == ST_FOLD) |-> (pos == 6'd0), "compression started off a block boundary")
  `SHA1_ASSERT(a_out_after_tail, (state == ST_OUT) |-> (pos == 6'd0 && !pad_first && ending), "digest shown before the final block")

endmodule
